// ===== hdl/mve_pkg.sv =====
// MessagePack value encoder: shared types and constants.
// Used by every module of the encoder; depends on nothing.

package mve_pkg;

	localparam int FuncW    = 3;
	localparam int FillW    = 16;
	localparam int CountW   = 32;
	localparam int MaxBytes = 5;
	localparam int NbW      = 3;
	localparam int CfgIdxW  = 2;

	localparam logic [FuncW-1:0] FN_NIL      = 3'd0;
	localparam logic [FuncW-1:0] FN_BOOL     = 3'd1;
	localparam logic [FuncW-1:0] FN_INT      = 3'd2;
	localparam logic [FuncW-1:0] FN_ARRAY    = 3'd3;
	localparam logic [FuncW-1:0] FN_MAP      = 3'd4;
	localparam logic [FuncW-1:0] FN_STR_HDR  = 3'd5;
	localparam logic [FuncW-1:0] FN_STR_BYTE = 3'd6;
	localparam logic [FuncW-1:0] FN_UNUSED   = 3'd7;

	localparam logic [CfgIdxW-1:0] CFG_CAPACITY  = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_START_LEN = 2'd1;

	localparam logic [FillW-1:0] CapacityReset = 16'd256;
	localparam logic [FillW-1:0] StartLenReset = 16'd0;

	localparam logic [7:0] MP_NIL     = 8'hC0;
	localparam logic [7:0] MP_FALSE   = 8'hC2;
	localparam logic [7:0] MP_TRUE    = 8'hC3;
	localparam logic [7:0] MP_INT8    = 8'hD0;
	localparam logic [7:0] MP_INT16   = 8'hD1;
	localparam logic [7:0] MP_INT32   = 8'hD2;
	localparam logic [7:0] MP_FIXARR  = 8'h90;
	localparam logic [7:0] MP_ARR16   = 8'hDC;
	localparam logic [7:0] MP_ARR32   = 8'hDD;
	localparam logic [7:0] MP_FIXMAP  = 8'h80;
	localparam logic [7:0] MP_MAP16   = 8'hDE;
	localparam logic [7:0] MP_MAP32   = 8'hDF;
	localparam logic [7:0] MP_FIXSTR  = 8'hA0;
	localparam logic [7:0] MP_STR8    = 8'hD9;
	localparam logic [7:0] MP_STR16   = 8'hDA;
	localparam logic [7:0] MP_STR32   = 8'hDB;

	// one classified item: bytes in emission order, enc[0] first
	typedef struct packed {
		logic [MaxBytes-1:0][7:0] enc;
		logic [NbW-1:0]           nbytes;
		logic                     drop;
		logic [FillW-1:0]         fill_base;
	} desc_t;

endpackage

// ===== hdl/msgpack_value_encoder.sv =====
// MessagePack value encoder, top level: front end, descriptor queue, back end.
// Depends on mve_pkg, mve_front, mve_queue, mve_back.
//
// channel | dir | fields (low bit up)
// s_*     | in  | tdata: value[31:0], count[63:32], data_byte[71:64]; tuser: func
// m_*     | out | tdata: out_byte[7:0], fill_length[23:8]; tuser: dropped; tlast: last
// cfg_*   | in  | cfg_index (0 capacity, 1 start_length), cfg_data
//
// One byte leaves per cycle while m_tready allows; an item of n bytes leaves n bytes,
// five for a 32-bit field; a dropped item leaves as one zero byte. Items pass the queue
// and then the output register. Input stalls only when the descriptor queue is full;
// output stalls back up into the queue. Reset is asynchronous; no clearing pass follows it.

module msgpack_value_encoder #(
	parameter int QueueDepth = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // value, count, data_byte
	input  logic [2:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // out_byte, fill_length
	output logic        m_tuser,   // dropped
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;
	mve_pkg::desc_t q_in;
	mve_pkg::desc_t q_head;
	logic [7:0]     o_byte;
	logic [15:0]    o_fill;

	assign cfg_ready = 1'b1;
	assign m_tdata   = {o_fill, o_byte};

	mve_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.func      (s_tuser),
		.value     (s_tdata[31:0]),
		.count     (s_tdata[63:32]),
		.data_byte (s_tdata[71:64]),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_value (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (q_in)
	);

	mve_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	mve_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (o_byte),
		.out_last  (m_tlast),
		.out_drop  (m_tuser),
		.out_fill  (o_fill)
	);

endmodule

// ===== hdl/mve_front.sv =====
// Encoder front end: accepts items, builds the encoding, checks capacity and
// keeps the fill and open-string state. Depends on mve_pkg.

module mve_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mve_pkg::FuncW-1:0]     func,
	input  logic [31:0]                   value,
	input  logic [mve_pkg::CountW-1:0]    count,
	input  logic [7:0]                    data_byte,
	input  logic                          cfg_valid,
	input  logic [mve_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [mve_pkg::FillW-1:0]     cfg_value,
	input  logic                          q_full,
	output logic                          q_push,
	output mve_pkg::desc_t                q_desc
);

	logic [mve_pkg::FillW-1:0]  fill_q;
	logic [mve_pkg::FillW-1:0]  cap_q;
	logic [mve_pkg::CountW-1:0] str_rem_q;
	logic                       str_acc_q;

	logic [mve_pkg::MaxBytes-1:0][7:0] enc;
	logic [mve_pkg::NbW-1:0]           nb;
	logic                              fit;
	logic                              str_fit;
	logic                              drop;
	logic                              accept;
	logic [mve_pkg::CountW-1:0]        rem_dec;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;
	assign q_push   = accept && (func != mve_pkg::FN_UNUSED);
	assign rem_dec  = str_rem_q - 32'd1;

	always_comb begin
		enc = '0;
		nb  = 3'd1;
		unique case (func)
			mve_pkg::FN_NIL: enc[0] = mve_pkg::MP_NIL;
			mve_pkg::FN_BOOL: enc[0] = value[0] ? mve_pkg::MP_TRUE : mve_pkg::MP_FALSE;
			mve_pkg::FN_INT: begin
				if (value[31:7] == '0 || value[31:5] == '1) begin
					enc[0] = value[7:0];
				end else if (value[31:7] == '1) begin
					enc[0] = mve_pkg::MP_INT8;
					enc[1] = value[7:0];
					nb     = 3'd2;
				end else if (value[31:15] == '0 || value[31:15] == '1) begin
					enc[0] = mve_pkg::MP_INT16;
					enc[1] = value[15:8];
					enc[2] = value[7:0];
					nb     = 3'd3;
				end else begin
					enc[0] = mve_pkg::MP_INT32;
					enc[1] = value[31:24];
					enc[2] = value[23:16];
					enc[3] = value[15:8];
					enc[4] = value[7:0];
					nb     = 3'd5;
				end
			end
			mve_pkg::FN_ARRAY, mve_pkg::FN_MAP: begin
				if (count[31:4] == '0) begin
					enc[0] = ((func == mve_pkg::FN_MAP) ? mve_pkg::MP_FIXMAP
						: mve_pkg::MP_FIXARR) | {4'd0, count[3:0]};
				end else if (count[31:16] == '0) begin
					enc[0] = (func == mve_pkg::FN_MAP) ? mve_pkg::MP_MAP16 : mve_pkg::MP_ARR16;
					enc[1] = count[15:8];
					enc[2] = count[7:0];
					nb     = 3'd3;
				end else begin
					enc[0] = (func == mve_pkg::FN_MAP) ? mve_pkg::MP_MAP32 : mve_pkg::MP_ARR32;
					enc[1] = count[31:24];
					enc[2] = count[23:16];
					enc[3] = count[15:8];
					enc[4] = count[7:0];
					nb     = 3'd5;
				end
			end
			mve_pkg::FN_STR_HDR: begin
				if (count[31:5] == '0) begin
					enc[0] = mve_pkg::MP_FIXSTR | {3'd0, count[4:0]};
				end else if (count[31:8] == '0) begin
					enc[0] = mve_pkg::MP_STR8;
					enc[1] = count[7:0];
					nb     = 3'd2;
				end else if (count[31:16] == '0) begin
					enc[0] = mve_pkg::MP_STR16;
					enc[1] = count[15:8];
					enc[2] = count[7:0];
					nb     = 3'd3;
				end else begin
					enc[0] = mve_pkg::MP_STR32;
					enc[1] = count[31:24];
					enc[2] = count[23:16];
					enc[3] = count[15:8];
					enc[4] = count[7:0];
					nb     = 3'd5;
				end
			end
			mve_pkg::FN_STR_BYTE: enc[0] = data_byte;
			default: ;
		endcase
	end

	assign fit = ({1'b0, fill_q} + {14'd0, nb}) <= {1'b0, cap_q};
	assign str_fit = ({18'd0, fill_q} + {31'd0, nb} + {2'd0, count}) <= {18'd0, cap_q};

	always_comb begin
		case (func)
			mve_pkg::FN_STR_HDR: drop = !str_fit;
			mve_pkg::FN_STR_BYTE: drop = (str_rem_q == '0) || !str_acc_q || !fit;
			default: drop = !fit;
		endcase
	end

	assign q_desc.enc       = enc;
	assign q_desc.nbytes    = nb;
	assign q_desc.drop      = drop;
	assign q_desc.fill_base = fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= mve_pkg::StartLenReset;
			cap_q     <= mve_pkg::CapacityReset;
			str_rem_q <= '0;
			str_acc_q <= 1'b0;
		end else begin
			if (q_push) begin
				if (!drop) begin
					fill_q <= fill_q + {13'd0, nb};
				end
				if (func == mve_pkg::FN_STR_HDR) begin
					str_rem_q <= count;
					str_acc_q <= str_fit && (count != '0);
				end else if (func == mve_pkg::FN_STR_BYTE) begin
					if (str_rem_q == '0) begin
						str_acc_q <= 1'b0;
					end else begin
						str_rem_q <= rem_dec;
						if (rem_dec == '0) begin
							str_acc_q <= 1'b0;
						end
					end
				end
			end
			if (cfg_valid) begin
				case (cfg_index)
					mve_pkg::CFG_CAPACITY: cap_q <= cfg_value;
					mve_pkg::CFG_START_LEN: begin
						fill_q    <= cfg_value;
						str_rem_q <= '0;
						str_acc_q <= 1'b0;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== hdl/mve_queue.sv =====
// Small descriptor queue between encoder front and back end.
// Depends on mve_pkg for the descriptor type.

module mve_queue #(
	parameter int Depth = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mve_pkg::desc_t push_desc,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output mve_pkg::desc_t head
);

	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LastPtr = AW'(Depth - 1);
	localparam logic [CW-1:0] DepthC  = CW'(Depth);

	mve_pkg::desc_t  mem_q [Depth];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == DepthC);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LastPtr) ? '0 : wr_q + AW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LastPtr) ? '0 : rd_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/mve_back.sv =====
// Encoder back end: serializes queued encodings into the output register one
// byte per cycle while out_ready allows. Depends on mve_pkg.

module mve_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      q_empty,
	input  mve_pkg::desc_t            q_head,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                out_byte,
	output logic                      out_last,
	output logic                      out_drop,
	output logic [mve_pkg::FillW-1:0] out_fill
);

	logic [mve_pkg::NbW-1:0]   idx_q;
	logic                      vld_q;
	logic [7:0]                byte_q;
	logic                      last_q;
	logic                      drop_q;
	logic [mve_pkg::FillW-1:0] fill_q;
	logic                      load;
	logic                      take;
	logic                      is_last;
	logic [7:0]                cur_byte;
	logic [mve_pkg::FillW-1:0] cur_fill;

	assign load     = !vld_q || out_ready;
	assign take     = load && !q_empty;
	assign is_last  = q_head.drop || (idx_q == q_head.nbytes - 3'd1);
	assign q_pop    = take && is_last;
	assign cur_byte = q_head.drop ? 8'd0 : q_head.enc[idx_q];
	assign cur_fill = q_head.drop ? q_head.fill_base
		: q_head.fill_base + {13'd0, idx_q} + 16'd1;

	assign out_valid = vld_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign out_drop  = drop_q;
	assign out_fill  = fill_q;

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= cur_byte;
			last_q <= is_last;
			drop_q <= q_head.drop;
			fill_q <= cur_fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= !q_empty;
			if (take) begin
				idx_q <= is_last ? '0 : idx_q + 3'd1;
			end
		end
	end

endmodule
